// ===== src/sasp_pkg.sv =====
`timescale 1ns / 1ps

package sasp_pkg;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_SWEEP = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MAX_DEGREE = 3'd0,
    REG_MIN_PULSE  = 3'd1,
    REG_MAX_PULSE  = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_DUTY_BITS  = 3'd4
  } reg_idx_t;

  localparam int ANGLE_W   = 9;
  localparam int PULSE_W   = 13;
  localparam int PERIOD_W  = 20;
  localparam int BITS_W    = 5;
  localparam int DELAY_W   = 16;
  localparam int DUTY_W    = 20;

  localparam int PROD_W    = ANGLE_W + PULSE_W;        // |angle * pulse span|
  localparam int SPULSE_W  = PROD_W + 2;               // signed pulse sum
  localparam int NUM_W     = PROD_W + 1 + DUTY_W;      // pulse * full scale
  localparam int CNT_W     = 6;

  localparam logic [BITS_W-1:0]   MAX_BITS       = 5'd20;
  localparam logic [ANGLE_W-1:0]  NEUTRAL_ANGLE  = 9'd90;
  localparam logic [ANGLE_W-1:0]  RST_MAX_DEGREE = 9'd180;
  localparam logic [PULSE_W-1:0]  RST_MIN_PULSE  = 13'd500;
  localparam logic [PULSE_W-1:0]  RST_MAX_PULSE  = 13'd2500;
  localparam logic [PERIOD_W-1:0] RST_PERIOD     = 20'd20000;
  localparam logic [BITS_W-1:0]   RST_DUTY_BITS  = 5'd13;

endpackage

// ===== src/servo_angle_sweep_pwm.sv =====
`timescale 1ns / 1ps
// sequence: set, sweep and a tick that steps the angle run the multiply, then a
// 22-step angle-to-pulse division, then a 43-step pulse-to-duty division, both
// on one shared restoring divider; other ticks and unknown codes go straight to S_FINISH
// throughput: one beat at a time, s_tready high only while the sequencer is idle
// reset: synchronous, angle 90, no sweep, duty 0, registers to their defaults
module servo_angle_sweep_pwm (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // angle[9:0], step_delay[25:10], zero fill
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // duty[19:0], angle_now[28:20], moving[29],
                                 // duty_changed[30], zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_PULSE,
    S_DIV2,
    S_SAT,
    S_FINISH
  } state_t;

  localparam int AW = sasp_pkg::ANGLE_W;
  localparam int PW = sasp_pkg::PULSE_W;
  localparam int DW = sasp_pkg::PERIOD_W;
  localparam int NW = sasp_pkg::NUM_W;

  state_t state;

  logic [AW-1:0]              max_degree;
  logic [PW-1:0]              min_pulse_us;
  logic [PW-1:0]              max_pulse_us;
  logic [DW-1:0]              pwm_period_us;
  logic [sasp_pkg::BITS_W-1:0] duty_bits;

  logic [AW-1:0]                 current_angle;
  logic [AW-1:0]                 target_angle;
  logic                          sweeping;
  logic                          step_down;
  logic [sasp_pkg::DELAY_W-1:0]  delay_reload;
  logic [sasp_pkg::DELAY_W-1:0]  delay_left;
  logic [sasp_pkg::DUTY_W-1:0]   duty_now;
  logic                          changed;
  logic                          span_neg;

  logic [NW-1:0]               div_num;
  logic [DW-1:0]               div_rem;
  logic [DW-1:0]               div_den;
  logic [sasp_pkg::CNT_W-1:0]  div_count;

  // input beat fields
  sasp_pkg::op_t               in_op;
  logic signed [9:0]           in_angle;
  logic [sasp_pkg::DELAY_W-1:0] in_delay;
  logic [AW-1:0]               clamped;
  logic [AW-1:0]               sweep_start;

  // configuration
  logic                        cfg_wr;
  sasp_pkg::reg_idx_t          cfg_idx;

  // shared divider step
  logic [DW:0]                 trial;
  logic                        trial_ge;
  logic [DW-1:0]               rem_next;
  logic [NW-1:0]               num_next;

  // angle to pulse
  logic signed [PW:0]          span;
  logic [PW-1:0]               span_mag;
  logic [sasp_pkg::PROD_W-1:0] prod;
  logic [sasp_pkg::PROD_W-1:0] quot1;
  logic signed [sasp_pkg::SPULSE_W-1:0] pulse_s;
  logic [sasp_pkg::PROD_W:0]   pulse;
  logic [NW-1:0]               numer;

  logic [sasp_pkg::BITS_W-1:0] bits;
  logic [sasp_pkg::DUTY_W-1:0] full_scale;

  assign in_op    = sasp_pkg::op_t'(s_tuser);
  assign in_angle = s_tdata[9:0];
  assign in_delay = s_tdata[25:10];

  always_comb begin
    if (in_angle[9]) begin
      clamped = '0;
    end else if (in_angle[8:0] > max_degree) begin
      clamped = max_degree;
    end else begin
      clamped = in_angle[8:0];
    end
    sweep_start = (current_angle > max_degree) ? max_degree : current_angle;
  end

  assign s_tready = (state == S_IDLE);
  assign pready   = 1'b1;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = sasp_pkg::reg_idx_t'(paddr[4:2]);

  always_comb begin
    unique case (paddr[4:2])
      sasp_pkg::REG_MAX_DEGREE: prdata = {23'd0, max_degree};
      sasp_pkg::REG_MIN_PULSE:  prdata = {19'd0, min_pulse_us};
      sasp_pkg::REG_MAX_PULSE:  prdata = {19'd0, max_pulse_us};
      sasp_pkg::REG_PERIOD:     prdata = {12'd0, pwm_period_us};
      sasp_pkg::REG_DUTY_BITS:  prdata = {27'd0, duty_bits};
      default:                  prdata = '0;
    endcase
  end

  always_comb begin
    bits       = (duty_bits > sasp_pkg::MAX_BITS) ? sasp_pkg::MAX_BITS : duty_bits;
    full_scale = sasp_pkg::DUTY_W'(({1'b0, {sasp_pkg::DUTY_W{1'b0}}} | (21'd1 << bits))
                 - 21'd1);
  end

  always_comb begin
    trial    = {div_rem, div_num[NW-1]};
    trial_ge = (trial >= {1'b0, div_den});
    rem_next = trial_ge ? DW'(trial - {1'b0, div_den}) : DW'(trial);
    num_next = {div_num[NW-2:0], trial_ge};
  end

  always_comb begin
    span     = $signed({1'b0, max_pulse_us}) - $signed({1'b0, min_pulse_us});
    span_mag = span[PW] ? PW'(-span) : span[PW-1:0];
    prod     = {{(sasp_pkg::PROD_W-AW){1'b0}}, current_angle}
               * {{(sasp_pkg::PROD_W-PW){1'b0}}, span_mag};
    quot1    = div_num[sasp_pkg::PROD_W-1:0];
    pulse_s  = $signed({{(sasp_pkg::SPULSE_W-PW){1'b0}}, min_pulse_us})
               + (span_neg ? -$signed({2'b00, quot1}) : $signed({2'b00, quot1}));
    pulse    = pulse_s[sasp_pkg::SPULSE_W-1] ? '0 : pulse_s[sasp_pkg::PROD_W:0];
    numer    = ({{sasp_pkg::DUTY_W{1'b0}}, pulse} << bits)
               - {{sasp_pkg::DUTY_W{1'b0}}, pulse};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_degree    <= sasp_pkg::RST_MAX_DEGREE;
      min_pulse_us  <= sasp_pkg::RST_MIN_PULSE;
      max_pulse_us  <= sasp_pkg::RST_MAX_PULSE;
      pwm_period_us <= sasp_pkg::RST_PERIOD;
      duty_bits     <= sasp_pkg::RST_DUTY_BITS;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sasp_pkg::REG_MAX_DEGREE: max_degree    <= pwdata[AW-1:0];
        sasp_pkg::REG_MIN_PULSE:  min_pulse_us  <= pwdata[PW-1:0];
        sasp_pkg::REG_MAX_PULSE:  max_pulse_us  <= pwdata[PW-1:0];
        sasp_pkg::REG_PERIOD:     pwm_period_us <= pwdata[DW-1:0];
        sasp_pkg::REG_DUTY_BITS:  duty_bits     <= pwdata[sasp_pkg::BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      current_angle <= sasp_pkg::NEUTRAL_ANGLE;
      target_angle  <= '0;
      sweeping      <= 1'b0;
      step_down     <= 1'b0;
      delay_reload  <= '0;
      delay_left    <= '0;
      duty_now      <= '0;
      changed       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      // the result register is only loaded in S_FINISH, which holds it while stalled
      if (m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (in_op)
              sasp_pkg::OP_SET: begin
                sweeping      <= 1'b0;
                current_angle <= clamped;
                changed       <= 1'b1;
                state         <= S_MUL;
              end
              sasp_pkg::OP_SWEEP: begin
                target_angle  <= clamped;
                step_down     <= !(clamped > sweep_start);
                delay_reload  <= in_delay;
                delay_left    <= in_delay;
                sweeping      <= 1'b1;
                current_angle <= sweep_start;
                changed       <= 1'b1;
                state         <= S_MUL;
              end
              sasp_pkg::OP_TICK: begin
                if (sweeping) begin
                  if (delay_left > 16'd1) begin
                    delay_left <= delay_left - 16'd1;
                    changed    <= 1'b0;
                    state      <= S_FINISH;
                  end else if (current_angle == target_angle) begin
                    sweeping   <= 1'b0;
                    delay_left <= '0;
                    changed    <= 1'b0;
                    state      <= S_FINISH;
                  end else begin
                    current_angle <= step_down ? current_angle - 9'd1
                                               : current_angle + 9'd1;
                    delay_left    <= delay_reload;
                    changed       <= 1'b1;
                    state         <= S_MUL;
                  end
                end else begin
                  changed <= 1'b0;
                  state   <= S_FINISH;
                end
              end
              default: begin
                changed <= 1'b0;
                state   <= S_FINISH;
              end
            endcase
          end
        end
        S_MUL: begin
          span_neg <= span[PW];
          div_rem  <= '0;
          div_den  <= {{(DW-AW){1'b0}}, max_degree};
          if (max_degree == '0) begin
            div_num <= '0;
            state   <= S_PULSE;
          end else begin
            div_num   <= {prod, {(NW-sasp_pkg::PROD_W){1'b0}}};
            div_count <= sasp_pkg::CNT_W'(sasp_pkg::PROD_W);
            state     <= S_DIV1;
          end
        end
        S_DIV1: begin
          div_num   <= num_next;
          div_rem   <= rem_next;
          div_count <= div_count - 1'b1;
          if (div_count == sasp_pkg::CNT_W'(1)) begin
            state <= S_PULSE;
          end
        end
        S_PULSE: begin
          if (pwm_period_us == '0) begin
            duty_now <= full_scale;
            state    <= S_FINISH;
          end else begin
            div_num   <= numer;
            div_rem   <= '0;
            div_den   <= pwm_period_us;
            div_count <= sasp_pkg::CNT_W'(NW);
            state     <= S_DIV2;
          end
        end
        S_DIV2: begin
          div_num   <= num_next;
          div_rem   <= rem_next;
          div_count <= div_count - 1'b1;
          if (div_count == sasp_pkg::CNT_W'(1)) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          if ((|div_num[NW-1:sasp_pkg::DUTY_W]) ||
              (div_num[sasp_pkg::DUTY_W-1:0] > full_scale)) begin
            duty_now <= full_scale;
          end else begin
            duty_now <= div_num[sasp_pkg::DUTY_W-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {1'b0, changed, sweeping, current_angle, duty_now};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF  = 5;
  localparam int RST_CYC   = 7;
  localparam int LIMIT     = 2000000;
  localparam int PHASE_LEN = 222;
  localparam int HOLD_CYC  = 400;
  localparam int N_DIR     = 24;
  localparam int N_CFG     = 9;

  typedef struct packed {
    logic [19:0] duty;
    logic [8:0]  ang_now;
    logic        moving;
    logic        changed;
  } servo_status_t;

  typedef struct packed {
    sasp_pkg::op_t      op;
    logic signed [9:0]  ang;
    logic [15:0]        dly;
    logic               fixed;
    servo_status_t      want;
  } dir_row_t;

  typedef struct packed {
    logic [8:0]  deg;
    logic [12:0] minp;
    logic [12:0] maxp;
    logic [19:0] per;
    logic [4:0]  bits;
  } servo_cfg_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // angle[9:0], step_delay[25:10], zero fill
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // duty[19:0], angle_now[28:20], moving[29],
                               // duty_changed[30], zero fill
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_angle_sweep_pwm u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #CLK_HALF clk = ~clk;

  // predictor copy of registers and state
  logic [8:0]  cfg_deg   = sasp_pkg::RST_MAX_DEGREE;
  logic [12:0] cfg_minp  = sasp_pkg::RST_MIN_PULSE;
  logic [12:0] cfg_maxp  = sasp_pkg::RST_MAX_PULSE;
  logic [19:0] cfg_per   = sasp_pkg::RST_PERIOD;
  logic [4:0]  cfg_bits  = sasp_pkg::RST_DUTY_BITS;
  logic [8:0]  p_angle   = sasp_pkg::NEUTRAL_ANGLE;
  logic [8:0]  p_target  = '0;
  logic        p_sweep   = 1'b0;
  logic        p_down    = 1'b0;
  logic [15:0] p_reload  = '0;
  logic [15:0] p_left    = '0;
  logic [19:0] p_duty    = '0;

  servo_status_t status_q[$];
  servo_status_t cur_want;
  servo_status_t seen;
  servo_status_t want;
  logic          cur_fixed = 1'b0;
  int            n_err = 0;
  int            cycles = 0;
  int            idle_pct = 28;
  bit            hold_req = 1'b0;

  dir_row_t   dir_tab [N_DIR];
  servo_cfg_t cfg_tab [N_CFG];

  function automatic logic [19:0] duty_of(logic [8:0] a);
    longint          pulse;
    int unsigned     bits;
    longint unsigned full;
    longint unsigned d;
    pulse = longint'(cfg_minp);
    if (cfg_deg != 0)
      pulse += (longint'(a) * (longint'(cfg_maxp) - longint'(cfg_minp))) / longint'(cfg_deg);
    if (pulse < 0) pulse = 0;
    bits = (cfg_bits > sasp_pkg::MAX_BITS) ? 20 : int'(cfg_bits);
    full = (64'd1 << bits) - 64'd1;
    if (cfg_per == 0) return full[19:0];
    d = (longint'(pulse) * full) / longint'(cfg_per);
    if (d > full) d = full;
    return d[19:0];
  endfunction

  function automatic logic [8:0] clamp_deg(logic signed [9:0] a);
    if (a < 0) return '0;
    if (int'(a) > int'(cfg_deg)) return cfg_deg;
    return a[8:0];
  endfunction

  function automatic servo_status_t next_servo_status(sasp_pkg::op_t op,
                                                      logic signed [9:0] ang,
                                                      logic [15:0] dly);
    logic [8:0]    start;
    servo_status_t r;
    logic          chg;
    chg = 1'b0;
    case (op)
      sasp_pkg::OP_SET: begin
        p_sweep = 1'b0;
        p_angle = clamp_deg(ang);
        p_duty  = duty_of(p_angle);
        chg     = 1'b1;
      end
      sasp_pkg::OP_SWEEP: begin
        start    = (p_angle > cfg_deg) ? cfg_deg : p_angle;
        p_target = clamp_deg(ang);
        p_down   = !(p_target > start);
        p_reload = dly;
        p_left   = dly;
        p_sweep  = 1'b1;
        p_angle  = start;
        p_duty   = duty_of(start);
        chg      = 1'b1;
      end
      sasp_pkg::OP_TICK: begin
        if (p_sweep) begin
          if (p_left > 1) begin
            p_left = p_left - 1'b1;
          end else if (p_angle == p_target) begin
            p_sweep = 1'b0;
            p_left  = '0;
          end else begin
            p_angle = p_down ? p_angle - 1'b1 : p_angle + 1'b1;
            p_duty  = duty_of(p_angle);
            p_left  = p_reload;
            chg     = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.duty    = p_duty;
    r.ang_now = p_angle;
    r.moving  = p_sweep;
    r.changed = chg;
    return r;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("** servo_angle_sweep_pwm: FAILED **");
      $finish;
    end else if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = next_servo_status(sasp_pkg::op_t'(s_tuser), s_tdata[9:0], s_tdata[25:10]);
        if (cur_fixed) want = cur_want;
        status_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        seen = {m_tdata[19:0], m_tdata[28:20], m_tdata[29], m_tdata[30]};
        if (status_q.size() == 0) begin
          $error("unexpected beat: duty %0d angle_now %0d", seen.duty, seen.ang_now);
          n_err++;
        end else begin
          want = status_q.pop_front();
          if (seen.duty !== want.duty) begin
            $error("duty: expected %0d, got %0d", want.duty, seen.duty);
            n_err++;
          end
          if (seen.ang_now !== want.ang_now) begin
            $error("angle_now: expected %0d, got %0d", want.ang_now, seen.ang_now);
            n_err++;
          end
          if (seen.moving !== want.moving) begin
            $error("moving: expected %0d, got %0d", want.moving, seen.moving);
            n_err++;
          end
          if (seen.changed !== want.changed) begin
            $error("duty_changed: expected %0d, got %0d", want.changed, seen.changed);
            n_err++;
          end
        end
      end
    end
  end

  // result side back-pressure
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  task automatic send_item(sasp_pkg::op_t op, logic signed [9:0] ang, logic [15:0] dly,
                           logic fixed, servo_status_t exp_st);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= {6'd0, dly, ang};
    s_tuser   <= op;
    cur_fixed  = fixed;
    cur_want   = exp_st;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(servo_cfg_t c);
    logic [31:0]        vals [5];
    sasp_pkg::reg_idx_t idx [5];
    vals = '{32'(c.deg), 32'(c.minp), 32'(c.maxp), 32'(c.per), 32'(c.bits)};
    idx  = '{sasp_pkg::REG_MAX_DEGREE, sasp_pkg::REG_MIN_PULSE, sasp_pkg::REG_MAX_PULSE,
             sasp_pkg::REG_PERIOD, sasp_pkg::REG_DUTY_BITS};
    for (int i = 0; i < 5; i++) begin
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {idx[i], 2'b00};
      pwdata  <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_deg  = c.deg;
    cfg_minp = c.minp;
    cfg_maxp = c.maxp;
    cfg_per  = c.per;
    cfg_bits = c.bits;
  endtask

  function automatic logic signed [9:0] pick_angle();
    int t;
    case ($urandom_range(0, 9))
      0, 1: return 10'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return -10'sd512;
          1: return 10'sd511;
          2: return 10'sd0;
          default: return 10'(cfg_deg);
        endcase
      end
      default: begin
        t = int'(p_angle) + int'($urandom_range(0, 24)) - 12;
        return t[9:0];
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_delay();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return 16'($urandom_range(0, 2));
    if (r < 18) return 16'($urandom_range(3, 30));
    return 16'($urandom);
  endfunction

  // command then a run of ticks, with some noise mixed in
  task automatic run_sweeps(int quota);
    int            sent;
    int            n;
    int            c;
    sasp_pkg::op_t op;
    sent = 0;
    while (sent < quota) begin
      c = $urandom_range(0, 99);
      op = (c < 55) ? sasp_pkg::OP_SWEEP : (c < 90) ? sasp_pkg::OP_SET : sasp_pkg::OP_NONE;
      send_item(op, pick_angle(), pick_delay(), 1'b0, '0);
      sent++;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      for (int k = 0; k < n && sent < quota; k++) begin
        op = ($urandom_range(0, 19) == 0) ? sasp_pkg::OP_NONE : sasp_pkg::OP_TICK;
        send_item(op, 10'($urandom), 16'($urandom), 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin
    dir_tab = '{
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b1, '{20'd0,    9'd90,  1'b0, 1'b0}},
      '{sasp_pkg::OP_NONE,  10'sd0,    16'd0,     1'b1, '{20'd0,    9'd90,  1'b0, 1'b0}},
      '{sasp_pkg::OP_SET,   10'sd0,    16'd0,     1'b1, '{20'd204,  9'd0,   1'b0, 1'b1}},
      '{sasp_pkg::OP_SET,   10'sd180,  16'd0,     1'b1, '{20'd1023, 9'd180, 1'b0, 1'b1}},
      '{sasp_pkg::OP_SET,   -10'sd512, 16'd0,     1'b1, '{20'd204,  9'd0,   1'b0, 1'b1}},
      '{sasp_pkg::OP_SET,   10'sd511,  16'd0,     1'b1, '{20'd1023, 9'd180, 1'b0, 1'b1}},
      '{sasp_pkg::OP_SET,   10'sd90,   16'd0,     1'b1, '{20'd614,  9'd90,  1'b0, 1'b1}},
      '{sasp_pkg::OP_SWEEP, 10'sd92,   16'd0,     1'b1, '{20'd614,  9'd90,  1'b1, 1'b1}},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_SWEEP, 10'sd90,   16'd3,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_SWEEP, 10'sd91,   16'd1,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_SWEEP, 10'sd0,    16'd65535, 1'b0, '0},
      '{sasp_pkg::OP_TICK,  -10'sd1,   16'd65535, 1'b0, '0},
      '{sasp_pkg::OP_SET,   10'sd45,   16'd0,     1'b0, '0},
      '{sasp_pkg::OP_TICK,  10'sd0,    16'd0,     1'b0, '0},
      '{sasp_pkg::OP_SWEEP, -10'sd1,   16'd65535, 1'b0, '0},
      '{sasp_pkg::OP_NONE,  10'sd511,  16'd65535, 1'b0, '0}
    };
    cfg_tab = '{
      '{9'd1,   13'd0,    13'd8191, 20'd1,       5'd20},
      '{9'd360, 13'd1000, 13'd2000, 20'd20000,   5'd16},
      '{9'd180, 13'd500,  13'd2500, 20'd20000,   5'd13},
      '{9'd0,   13'd300,  13'd4000, 20'd1000,    5'd10},
      '{9'd90,  13'd2500, 13'd500,  20'd20000,   5'd12},
      '{9'd511, 13'd8191, 13'd0,    20'd1048575, 5'd31},
      '{9'd200, 13'd500,  13'd2500, 20'd0,       5'd8},
      '{9'd45,  13'd1000, 13'd2000, 20'd5000,    5'd0},
      '{9'd180, 13'd544,  13'd2400, 20'd20000,   5'd14}
    };

    repeat (RST_CYC) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIR; i++)
      send_item(dir_tab[i].op, dir_tab[i].ang, dir_tab[i].dly, dir_tab[i].fixed,
                dir_tab[i].want);
    drain();

    for (int ph = 0; ph < N_CFG; ph++) begin
      write_cfg(cfg_tab[ph]);
      idle_pct = (ph == 2) ? 0 : 28;
      if (ph == 1) hold_req = 1'b1;
      run_sweeps(PHASE_LEN / 2);
      // sender waits for the block to empty
      if (ph == 4) drain();
      run_sweeps(PHASE_LEN - PHASE_LEN / 2);
      drain();
    end

    idle_pct = 28;
    repeat (100) @(negedge clk);
    if (n_err == 0 && status_q.size() == 0)
      $display("** servo_angle_sweep_pwm: PASSED **");
    else
      $display("** servo_angle_sweep_pwm: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
src/sasp_pkg.sv
src/servo_angle_sweep_pwm.sv
verif/tb_top.sv
